@@ sv/mmb_pkg.sv @@
// ----------------------------------------------------------------------------
// mmb_pkg
// Shared constants and types of the mono mix min/max peak bucketer.
// ----------------------------------------------------------------------------
package mmb_pkg;

	// channel lanes carried by one frame
	localparam int NUM_LANES = 8;
	localparam int LANE_W    = 3;

	// configuration register widths and reset values
	localparam int CH_W      = 4;
	localparam int FRM_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic [CH_W-1:0]  CH_RESET  = 4'd2;
	localparam logic [FRM_W-1:0] FRM_RESET = 16'd256;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_FRAMES = 2'd1;

	// per-stage control that travels with a request
	typedef struct packed {
		logic valid;
		logic last;
	} mmb_ctl_t;

endpackage

@@ sv/mono_mix_min_max_peak_bucketer.sv @@
// ----------------------------------------------------------------------------
// mono_mix_min_max_peak_bucketer
// Mixes multichannel frames to mono and emits min/max peaks per bucket.
// ----------------------------------------------------------------------------
// Usage:
// Frames enter on the frame channel (frame_valid/frame_ready), one frame of
// eight channel samples plus last_frame per request. The first channel_count
// lanes are averaged, truncated toward zero, into one mono sample.
// A closed bucket leaves on the bucket channel (bucket_valid/bucket_ready)
// with its min, max, frame count and final flag; a bucket closes when its
// count reaches bucket_frames or a frame marked last_frame arrives.
// Throughput is one frame per cycle: eight lanes work in parallel, then an
// adder tree and a reciprocal divide run as a four-stage pipeline.
// A closing frame's bucket turns valid in the output register behind the last stage.
// When the receiver stalls with a bucket waiting, the whole pipeline holds
// and frame_ready drops until the bucket is taken.
// Reset clears the pipeline and the open bucket, and loads channel_count = 2
// and bucket_frames = 256. Configuration is written through cfg_write,
// cfg_index and cfg_data while no frame is in flight.
// ----------------------------------------------------------------------------
module mono_mix_min_max_peak_bucketer #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [mmb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mmb_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             frame_valid,
	output logic                             frame_ready,
	input  logic signed [SAMPLE_BITS-1:0]    sample_ch0,
	input  logic signed [SAMPLE_BITS-1:0]    sample_ch1,
	input  logic signed [SAMPLE_BITS-1:0]    sample_ch2,
	input  logic signed [SAMPLE_BITS-1:0]    sample_ch3,
	input  logic signed [SAMPLE_BITS-1:0]    sample_ch4,
	input  logic signed [SAMPLE_BITS-1:0]    sample_ch5,
	input  logic signed [SAMPLE_BITS-1:0]    sample_ch6,
	input  logic signed [SAMPLE_BITS-1:0]    sample_ch7,
	input  logic                             last_frame,
	output logic                             bucket_valid,
	input  logic                             bucket_ready,
	output logic signed [SAMPLE_BITS-1:0]    bucket_min,
	output logic signed [SAMPLE_BITS-1:0]    bucket_max,
	output logic [mmb_pkg::FRM_W-1:0]        frames_seen,
	output logic                             is_final
);
	import mmb_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + 3;

	logic [CH_W-1:0]                              ch_cnt_q;
	logic [FRM_W-1:0]                             bucket_len_q;
	logic [LANE_W-1:0]                            nm1;
	logic [LANE_W-1:0]                            nm1_s1;
	logic                                         adv;
	mmb_ctl_t                                     ctl_s1, ctl_s4;
	logic signed [SAMPLE_BITS-1:0]                samples [NUM_LANES];
	logic signed [NUM_LANES-1:0][SUM_W-1:0]       lanes_s1;
	logic signed [SAMPLE_BITS-1:0]                mono_s4;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_cnt_q     <= CH_RESET;
			bucket_len_q <= FRM_RESET;
		end else if (cfg_write) begin
			if (cfg_index == REG_CHANNEL_COUNT) begin
				ch_cnt_q <= cfg_data[CH_W-1:0];
			end else if (cfg_index == REG_BUCKET_FRAMES) begin
				bucket_len_q <= cfg_data[FRM_W-1:0];
			end
		end
	end

	// clamp channel count to 1 .. NUM_LANES, kept as count minus one
	always_comb begin
		if (ch_cnt_q == '0) begin
			nm1 = '0;
		end else if (ch_cnt_q > CH_W'(NUM_LANES)) begin
			nm1 = LANE_W'(NUM_LANES - 1);
		end else begin
			nm1 = LANE_W'(ch_cnt_q - CH_W'(1));
		end
	end

	// pipeline moves unless a bucket is stuck in the output register
	assign adv         = !bucket_valid || bucket_ready;
	assign frame_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= frame_valid;
			ctl_s1.last  <= last_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nm1_s1 <= nm1;
		end
	end

	assign samples[0] = sample_ch0;
	assign samples[1] = sample_ch1;
	assign samples[2] = sample_ch2;
	assign samples[3] = sample_ch3;
	assign samples[4] = sample_ch4;
	assign samples[5] = sample_ch5;
	assign samples[6] = sample_ch6;
	assign samples[7] = sample_ch7;

	// channel lanes
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		mmb_lane #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.LANE_IDX   (i)
		) u_lane (
			.clk      (clk),
			.en       (adv),
			.sample   (samples[i]),
			.last_lane(nm1),
			.lane_s1  (lanes_s1[i])
		);
	end

	// sum and divide
	mmb_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ctl_s1  (ctl_s1),
		.nm1_s1  (nm1_s1),
		.lanes_s1(lanes_s1),
		.ctl_s4  (ctl_s4),
		.mono_s4 (mono_s4)
	);

	// bucket tracking and output register
	mmb_track #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.ctl_s4      (ctl_s4),
		.mono_s4     (mono_s4),
		.bucket_len  (bucket_len_q),
		.bucket_valid(bucket_valid),
		.bucket_min  (bucket_min),
		.bucket_max  (bucket_max),
		.frames_seen (frames_seen),
		.is_final    (is_final)
	);

endmodule

@@ sv/mmb_lane.sv @@
// ----------------------------------------------------------------------------
// mmb_lane
// One channel lane: gates the sample by channel count and sign-extends it
// into the width of the mono sum, registered as pipeline stage one.
// ----------------------------------------------------------------------------
module mmb_lane #(
	parameter int SAMPLE_BITS = 16,
	parameter int LANE_IDX    = 0
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic [mmb_pkg::LANE_W-1:0]            last_lane,
	output logic signed [SAMPLE_BITS+2:0]         lane_s1
);
	import mmb_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + 3;

	logic                    active;
	logic signed [SUM_W-1:0] lane_d;

	// lanes beyond the channel count contribute zero
	assign active = (LANE_W'(LANE_IDX) <= last_lane);
	assign lane_d = active ? {{3{sample[SAMPLE_BITS-1]}}, sample} : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= lane_d;
		end
	end

endmodule

@@ sv/mmb_merge.sv @@
// ----------------------------------------------------------------------------
// mmb_merge
// Merges the lane values: adder tree, then a truncating divide by the
// channel count through a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module mmb_merge #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        en,
	input  mmb_pkg::mmb_ctl_t                           ctl_s1,
	input  logic [mmb_pkg::LANE_W-1:0]                  nm1_s1,
	input  logic signed [mmb_pkg::NUM_LANES-1:0][SAMPLE_BITS+2:0] lanes_s1,
	output mmb_pkg::mmb_ctl_t                           ctl_s4,
	output logic signed [SAMPLE_BITS-1:0]               mono_s4
);
	import mmb_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + 3;
	localparam int K     = SUM_W;
	localparam int RW    = SUM_W + 1;
	localparam int PW    = SUM_W + RW;
	localparam int NW    = LANE_W + 1;
	localparam longint unsigned ONE_K = 64'd1 << K;

	// floor(2^K / n) for n = 1 .. 8, indexed by n - 1
	localparam logic [RW-1:0] RECIP [NUM_LANES] = '{
		RW'(ONE_K / 1), RW'(ONE_K / 2), RW'(ONE_K / 3), RW'(ONE_K / 4),
		RW'(ONE_K / 5), RW'(ONE_K / 6), RW'(ONE_K / 7), RW'(ONE_K / 8)
	};

	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        mag;

	mmb_ctl_t                ctl_s2, ctl_s3;
	logic [SUM_W-1:0]        mag_s2, mag_s3;
	logic                    neg_s2, neg_s3;
	logic [LANE_W-1:0]       nm1_s2, nm1_s3;
	logic [PW-1:0]           prod;
	logic [SUM_W-1:0]        quo_s3;

	logic [NW-1:0]           n3;
	logic [SUM_W+NW-1:0]     back;
	logic [SUM_W+NW-1:0]     rem;
	logic [SUM_W-1:0]        quo;
	logic [SUM_W-1:0]        mono_wide;

	// adder tree over all lanes
	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			sum = sum + lanes_s1[i];
		end
	end

	assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

	// stage two: sign and magnitude of the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag;
			neg_s2 <= sum[SUM_W-1];
			nm1_s2 <= nm1_s1;
		end
	end

	// stage three: reciprocal multiply, quotient estimate may be one low
	assign prod = PW'(mag_s2) * PW'(RECIP[nm1_s2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s3 <= prod[K +: SUM_W];
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			nm1_s3 <= nm1_s2;
		end
	end

	// stage four: correct the estimate and restore the sign
	assign n3        = {1'b0, nm1_s3} + NW'(1);
	assign back      = (SUM_W+NW)'(quo_s3) * (SUM_W+NW)'(n3);
	assign rem       = (SUM_W+NW)'(mag_s3) - back;
	assign quo       = (rem >= (SUM_W+NW)'(n3)) ? quo_s3 + SUM_W'(1) : quo_s3;
	assign mono_wide = neg_s3 ? SUM_W'(-quo) : quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mono_s4 <= mono_wide[SAMPLE_BITS-1:0];
		end
	end

endmodule

@@ sv/mmb_track.sv @@
// ----------------------------------------------------------------------------
// mmb_track
// Running min/max and frame count of the open bucket, plus the output
// register that holds a closed bucket until it is taken.
// ----------------------------------------------------------------------------
module mmb_track #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  mmb_pkg::mmb_ctl_t             ctl_s4,
	input  logic signed [SAMPLE_BITS-1:0] mono_s4,
	input  logic [mmb_pkg::FRM_W-1:0]     bucket_len,
	output logic                          bucket_valid,
	output logic signed [SAMPLE_BITS-1:0] bucket_min,
	output logic signed [SAMPLE_BITS-1:0] bucket_max,
	output logic [mmb_pkg::FRM_W-1:0]     frames_seen,
	output logic                          is_final
);
	import mmb_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] MIN_INIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] MAX_INIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] min_q, max_q;
	logic [FRM_W-1:0]              cnt_q;
	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] min_d, max_d;
	logic [FRM_W-1:0]              cnt_d, limit;
	logic                          close;

	// zero bucket length acts as one
	assign limit = (bucket_len == '0) ? FRM_W'(1) : bucket_len;

	assign min_d = (mono_s4 < min_q) ? mono_s4 : min_q;
	assign max_d = (mono_s4 > max_q) ? mono_s4 : max_q;
	assign cnt_d = cnt_q + FRM_W'(1);
	assign close = (cnt_d >= limit) || ctl_s4.last;

	// bucket tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_INIT;
			max_q <= MAX_INIT;
			cnt_q <= '0;
		end else if (en && ctl_s4.valid) begin
			if (close) begin
				min_q <= MIN_INIT;
				max_q <= MAX_INIT;
				cnt_q <= '0;
			end else begin
				min_q <= min_d;
				max_q <= max_d;
				cnt_q <= cnt_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_s4.valid && close;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl_s4.valid && close) begin
			bucket_min  <= min_d;
			bucket_max  <= max_d;
			frames_seen <= cnt_d;
			is_final    <= ctl_s4.last;
		end
	end

	assign bucket_valid = valid_q;

endmodule

@@ sv/mmb_checker.sv @@
// ----------------------------------------------------------------------------
// mmb_checker
// Port-level checks of the bucketer, bound to the top level.
// ----------------------------------------------------------------------------
module mmb_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             frame_ready,
	input  logic                             bucket_valid,
	input  logic                             bucket_ready,
	input  logic signed [SAMPLE_BITS-1:0]    bucket_min,
	input  logic signed [SAMPLE_BITS-1:0]    bucket_max,
	input  logic [mmb_pkg::FRM_W-1:0]        frames_seen,
	input  logic                             is_final
);
	import mmb_pkg::*;

	// a stalled bucket holds its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bucket_valid && !bucket_ready |=> bucket_valid && $stable(bucket_min)
			&& $stable(bucket_max) && $stable(frames_seen) && $stable(is_final))
		else $error("bucket changed while stalled");

	// a bucket always holds at least one frame, so min never exceeds max
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		bucket_valid |-> bucket_min <= bucket_max)
		else $error("bucket min above max");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		bucket_valid |-> frames_seen != '0)
		else $error("empty bucket emitted");

	// a stalled output stops new requests
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		bucket_valid && !bucket_ready |-> !frame_ready)
		else $error("request taken while output stalled");

endmodule

bind mono_mix_min_max_peak_bucketer mmb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mmb_checker (.*);

@@ test/mono_mix_min_max_peak_bucketer_test.sv @@
// ----------------------------------------------------------------------------
// mono_mix_min_max_peak_bucketer_test
// Self-checking bench for the mono mix min/max peak bucketer.
// Frames go in through a valid/ready sender with random gaps. Each accepted
// frame is mixed and tracked by a local bucket tracker, and each closed bucket
// is queued as the expected result. A receiver with random stalls compares
// every bucket that leaves the block field by field. Directed tests cover the
// register extremes and the odd cases. Random streams then run under several
// register settings.
// ----------------------------------------------------------------------------
module mono_mix_min_max_peak_bucketer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mmb_pkg::*;

	localparam int SMP_W = 16;
	localparam int PIPE_LATENCY = 4;
	localparam int CYCLE_LIMIT = 400000;

	// indexes past the register list, writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic signed [SMP_W-1:0] SMP_TOP = 16'sh7fff;
	localparam logic signed [SMP_W-1:0] SMP_BOTTOM = 16'sh8000;

	typedef struct {
		logic signed [SMP_W-1:0] lane [NUM_LANES];
		logic last;
	} frame_t;

	typedef struct {
		logic signed [SMP_W-1:0] lo;
		logic signed [SMP_W-1:0] hi;
		logic [FRM_W-1:0] count;
		logic fin;
	} bucket_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic frame_valid = 1'b0;
	logic frame_ready;
	logic signed [SMP_W-1:0] sample_ch0 = '0;
	logic signed [SMP_W-1:0] sample_ch1 = '0;
	logic signed [SMP_W-1:0] sample_ch2 = '0;
	logic signed [SMP_W-1:0] sample_ch3 = '0;
	logic signed [SMP_W-1:0] sample_ch4 = '0;
	logic signed [SMP_W-1:0] sample_ch5 = '0;
	logic signed [SMP_W-1:0] sample_ch6 = '0;
	logic signed [SMP_W-1:0] sample_ch7 = '0;
	logic last_frame = 1'b0;
	logic bucket_valid;
	logic bucket_ready = 1'b0;
	logic signed [SMP_W-1:0] bucket_min;
	logic signed [SMP_W-1:0] bucket_max;
	logic [FRM_W-1:0] frames_seen;
	logic is_final;

	// tracker copy of the block's registers and open bucket
	logic [CH_W-1:0] cfg_channels = CH_RESET;
	logic [FRM_W-1:0] cfg_frames = FRM_RESET;
	logic [FRM_W-1:0] open_count = '0;
	logic signed [SMP_W-1:0] open_min = SMP_TOP;
	logic signed [SMP_W-1:0] open_max = SMP_BOTTOM;

	bucket_t expected_buckets [$];

	int errors = 0;
	int cycles = 0;
	int frames_sent = 0;
	int buckets_checked = 0;
	int reg_writes = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;

	mono_mix_min_max_peak_bucketer #(
		.SAMPLE_BITS(SMP_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.sample_ch0(sample_ch0),
		.sample_ch1(sample_ch1),
		.sample_ch2(sample_ch2),
		.sample_ch3(sample_ch3),
		.sample_ch4(sample_ch4),
		.sample_ch5(sample_ch5),
		.sample_ch6(sample_ch6),
		.sample_ch7(sample_ch7),
		.last_frame(last_frame),
		.bucket_valid(bucket_valid),
		.bucket_ready(bucket_ready),
		.bucket_min(bucket_min),
		.bucket_max(bucket_max),
		.frames_seen(frames_seen),
		.is_final(is_final)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("mono_mix_min_max_peak_bucketer: mismatch");
			$finish;
		end
	end

	// no gap unless the pct draw hits; then mostly a short gap, sometimes a long one
	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic signed [SMP_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return SMP_TOP;
			1: return SMP_BOTTOM;
			2: return SMP_W'($signed($urandom_range(0, 8)) - 4);
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// mix one frame to mono and fold it into the open bucket
	task automatic mix_and_track(input frame_t f);
		int nch;
		int total;
		int c;
		logic signed [SMP_W-1:0] mono;
		logic [FRM_W-1:0] limit;
		bucket_t b;
		nch = int'(cfg_channels);
		if (nch == 0)
			nch = 1;
		if (nch > NUM_LANES)
			nch = NUM_LANES;
		total = 0;
		for (c = 0; c < nch; c++)
			total += f.lane[c];
		mono = SMP_W'(total / nch);
		if (mono < open_min)
			open_min = mono;
		if (mono > open_max)
			open_max = mono;
		open_count = open_count + 1'b1;
		limit = (cfg_frames == '0) ? FRM_W'(1) : cfg_frames;
		if (open_count >= limit || f.last) begin
			b.lo = open_min;
			b.hi = open_max;
			b.count = open_count;
			b.fin = f.last;
			expected_buckets.push_back(b);
			open_count = '0;
			open_min = SMP_TOP;
			open_max = SMP_BOTTOM;
		end
	endtask

	// send one frame request, valid stays up across back-to-back frames
	task automatic send_frame(input frame_t f);
		int gap;
		gap = pick_gap(idle_pct);
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch0 <= f.lane[0];
		sample_ch1 <= f.lane[1];
		sample_ch2 <= f.lane[2];
		sample_ch3 <= f.lane[3];
		sample_ch4 <= f.lane[4];
		sample_ch5 <= f.lane[5];
		sample_ch6 <= f.lane[6];
		sample_ch7 <= f.lane[7];
		last_frame <= f.last;
		frame_valid <= 1'b1;
		@(posedge clk);
		while (!frame_ready)
			@(posedge clk);
		frames_sent++;
		mix_and_track(f);
	endtask

	function automatic frame_t random_frame(input int last_pct);
		frame_t f;
		for (int i = 0; i < NUM_LANES; i++)
			f.lane[i] = pick_sample();
		f.last = ($urandom_range(0, 99) < last_pct);
		return f;
	endfunction

	function automatic frame_t flat_frame(input logic signed [SMP_W-1:0] v, input logic last);
		frame_t f;
		for (int i = 0; i < NUM_LANES; i++)
			f.lane[i] = v;
		f.last = last;
		return f;
	endfunction

	// stop sending and wait until every bucket is out and the pipe is empty
	task automatic drain_pipeline();
		frame_valid <= 1'b0;
		while (expected_buckets.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);
	endtask

	// register write, only called with the block idle; cfg_write is low again when it returns
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		reg_writes++;
		if (idx == REG_CHANNEL_COUNT)
			cfg_channels = data[CH_W-1:0];
		else if (idx == REG_BUCKET_FRAMES)
			cfg_frames = data[FRM_W-1:0];
	endtask

	// channel count with random junk above the field
	task automatic set_channels(input logic [CH_W-1:0] nch);
		logic [CFG_W-1:0] data;
		data = CFG_W'($urandom);
		data[CH_W-1:0] = nch;
		write_reg(REG_CHANNEL_COUNT, data);
	endtask

	// receiver: random stalls, compare each bucket with the oldest expectation
	always @(posedge clk) begin
		bucket_t want;
		int g;
		if (bucket_valid && bucket_ready) begin
			if (expected_buckets.size() == 0) begin
				$display("%0t unexpected bucket: min %0d max %0d frames %0d final %0d",
					$time, bucket_min, bucket_max, frames_seen, is_final);
				errors++;
			end else begin
				want = expected_buckets.pop_front();
				buckets_checked++;
				if (bucket_min !== want.lo) begin
					$display("%0t bucket_min: expected %0d, actual %0d", $time, want.lo, bucket_min);
					errors++;
				end
				if (bucket_max !== want.hi) begin
					$display("%0t bucket_max: expected %0d, actual %0d", $time, want.hi, bucket_max);
					errors++;
				end
				if (frames_seen !== want.count) begin
					$display("%0t frames_seen: expected %0d, actual %0d", $time, want.count,
						frames_seen);
					errors++;
				end
				if (is_final !== want.fin) begin
					$display("%0t is_final: expected %0d, actual %0d", $time, want.fin, is_final);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			bucket_ready <= 1'b0;
		end else begin
			g = pick_gap(stall_pct);
			if (g > 0) begin
				stall_left = g - 1;
				bucket_ready <= 1'b0;
			end else begin
				bucket_ready <= 1'b1;
			end
		end
	end

	// reset values: two channels, 256-frame buckets, closed by last frame
	task automatic test_reset_defaults();
		frame_t f;
		stall_pct = 30;
		send_frame(flat_frame(SMP_TOP, 1'b0));
		send_frame(flat_frame(SMP_BOTTOM, 1'b0));
		// opposite extremes and a negative odd sum, both truncate to zero
		f = flat_frame(16'sd0, 1'b0);
		f.lane[0] = SMP_BOTTOM;
		f.lane[1] = SMP_TOP;
		send_frame(f);
		f.lane[0] = -16'sd1;
		f.lane[1] = 16'sd0;
		f.last = 1'b1;
		send_frame(f);
		// bucket of a single frame
		send_frame(flat_frame(16'sd5, 1'b1));
		drain_pipeline();
	endtask

	// channel counts including zero and values past the lane count
	task automatic test_channel_counts();
		logic [CH_W-1:0] counts [6];
		frame_t f;
		counts = '{4'd0, 4'd1, 4'd3, 4'd8, 4'd9, 4'd15};
		// spare indexes must not touch either register
		write_reg(REG_SPARE_2, 16'hffff);
		write_reg(REG_SPARE_3, 16'h0000);
		foreach (counts[k]) begin
			set_channels(counts[k]);
			f = random_frame(0);
			if (counts[k] == 4'd3) begin
				// -2 / 3 truncates toward zero
				f.lane[0] = -16'sd1;
				f.lane[1] = -16'sd1;
				f.lane[2] = 16'sd0;
			end
			f.last = 1'b1;
			send_frame(f);
			drain_pipeline();
		end
	endtask

	// bucket lengths zero, one, maximum, and shortened mid-bucket
	task automatic test_bucket_lengths();
		set_channels(4'd4);
		write_reg(REG_BUCKET_FRAMES, 16'd0);
		repeat (3) send_frame(random_frame(0));
		drain_pipeline();
		write_reg(REG_BUCKET_FRAMES, 16'd1);
		send_frame(random_frame(0));
		drain_pipeline();
		write_reg(REG_BUCKET_FRAMES, 16'hffff);
		send_frame(flat_frame(SMP_TOP, 1'b0));
		send_frame(flat_frame(SMP_BOTTOM, 1'b0));
		send_frame(random_frame(0));
		send_frame(random_frame(100));
		drain_pipeline();
		// five frames into a ten-frame bucket, then shorten it to three
		write_reg(REG_BUCKET_FRAMES, 16'd10);
		repeat (5) send_frame(random_frame(0));
		drain_pipeline();
		write_reg(REG_BUCKET_FRAMES, 16'd3);
		send_frame(random_frame(0));
		drain_pipeline();
	endtask

	// random streams over many register settings and handshake patterns
	task automatic test_random_streams(input int phases, input int frames_per_phase);
		logic [CH_W-1:0] nch;
		logic [FRM_W-1:0] len;
		int last_pct;
		int r;
		for (int p = 0; p < phases; p++) begin
			case (p)
				0: begin nch = 4'd1; len = 16'd1; end
				1: begin nch = 4'd8; len = 16'hffff; end
				2: begin nch = 4'd15; len = 16'd0; end
				3: begin nch = 4'd0; len = 16'd2; end
				default: begin
					nch = CH_W'($urandom_range(0, 15));
					r = $urandom_range(0, 9);
					if (r < 6)
						len = FRM_W'($urandom_range(1, 16));
					else if (r == 6)
						len = '0;
					else if (r == 7)
						len = FRM_W'($urandom_range(17, 300));
					else
						len = FRM_W'($urandom_range(301, 65535));
				end
			endcase
			last_pct = (len > 64) ? 6 : 2;
			drain_pipeline();
			set_channels(nch);
			write_reg(REG_BUCKET_FRAMES, len);
			idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 55);
			stall_pct = (p % 4 == 0) ? 0 : ((p % 4 == 1) ? 20 : ((p % 4 == 2) ? 60 : 35));
			for (int i = 0; i < frames_per_phase; i++) begin
				send_frame(random_frame(last_pct));
				// sender holds off until all buckets are out, then resumes
				if (i == frames_per_phase / 2 && p % 5 == 2)
					drain_pipeline();
			end
		end
		drain_pipeline();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_channel_counts();
		test_bucket_lengths();
		test_random_streams(14, 62);
		$display("covered %0d frames and %0d buckets across %0d register writes",
			frames_sent, buckets_checked, reg_writes);
		if (errors == 0)
			$display("mono_mix_min_max_peak_bucketer: match");
		else
			$display("mono_mix_min_max_peak_bucketer: mismatch");
		$finish;
	end

endmodule

@@ mono_mix_min_max_peak_bucketer.f @@
sv/mmb_pkg.sv
sv/mmb_lane.sv
sv/mmb_merge.sv
sv/mmb_track.sv
sv/mono_mix_min_max_peak_bucketer.sv
sv/mmb_checker.sv
test/mono_mix_min_max_peak_bucketer_test.sv
